// ===== hdl/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg: shared types for the sorted set table
// Operation codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package bsst_pkg;
  localparam int unsigned ModeW = 2;
  localparam int unsigned RankW = 4;
  localparam int unsigned CapW  = 5;
  localparam int unsigned OutKeyW = 32;

  typedef enum logic [ModeW-1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, start search
    logic step;    // advance scan index
    logic commit;  // apply insert/erase and build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // lower bound found
  } sts_t;
endpackage

// ===== hdl/bsst_if.sv =====
// ----------------------------------------------------------------------------
// bsst_if: valid/ready channel
// Generic handshake carrying a packed payload.
// ----------------------------------------------------------------------------
interface bsst_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsst_ctrl: request sequencer
// Accept, scan for lower bound, commit, hold result until taken.
// ----------------------------------------------------------------------------
module bsst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bsst_pkg::sts_t sts_i,
  output bsst_pkg::cmd_t cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;
  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == S_SCAN) && !sts_i.scan_done;
    cmd_o.commit = (state_q == S_SCAN) && sts_i.scan_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_SCAN;
        S_SCAN: if (sts_i.scan_done) begin
          state_q     <= S_DONE;
          out_valid_q <= 1'b1;
        end
        S_DONE: if (out_ready_i) begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/bsst_dp.sv =====
// ----------------------------------------------------------------------------
// bsst_dp: key table datapath
// Register array of sorted keys, linear lower-bound scan, shift on commit.
// ----------------------------------------------------------------------------
module bsst_dp #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bsst_pkg::CapW-1:0]  cfg_data_i,
  input  bsst_pkg::cmd_t             cmd_i,
  output bsst_pkg::sts_t             sts_o,
  input  logic [bsst_pkg::ModeW-1:0] mode_i,
  input  logic [31:0]                key_i,
  input  logic [bsst_pkg::RankW-1:0] rank_i,
  output logic                       ok_o,
  output logic [31:0]                read_key_o,
  output logic [bsst_pkg::CapW-1:0]  entry_count_o
);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW   = (KEY_BITS < 32) ? KEY_BITS : 32;

  logic [KW-1:0]             keys_q [MAX_ENTRIES];
  logic [CntW-1:0]           count_q;
  logic [bsst_pkg::CapW-1:0] cap_q;
  logic [CntW-1:0]           pos_q;
  logic [KW-1:0]             key_q;
  bsst_pkg::op_e             op_q;
  logic [bsst_pkg::RankW-1:0] rank_q;
  logic                      ok_q;
  logic [31:0]               rd_q;

  logic          at_end, found, cap_ok;
  logic [KW-1:0] cur;
  logic [CntW:0] cap_x;

  assign cur    = keys_q[pos_q[IdxW-1:0]];
  assign at_end = (pos_q >= count_q);
  assign sts_o.scan_done = at_end || (cur >= key_q);
  assign found  = !at_end && (cur == key_q);
  assign cap_x  = (CntW + 1)'(cap_q);
  assign cap_ok = ({1'b0, count_q} < cap_x) && (count_q < CntW'(MAX_ENTRIES));

  assign ok_o          = ok_q;
  assign read_key_o    = rd_q;
  assign entry_count_o = bsst_pkg::CapW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bsst_pkg::CapW'(16);
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.commit) begin
        if (op_q == bsst_pkg::OP_INSERT && cap_ok && !found) count_q <= count_q + 1'b1;
        if (op_q == bsst_pkg::OP_ERASE && found) count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q  <= '0;
      key_q  <= key_i[KW-1:0];
      op_q   <= bsst_pkg::op_e'(mode_i);
      rank_q <= rank_i;
    end
    if (cmd_i.step) pos_q <= pos_q + 1'b1;
    if (cmd_i.commit) begin
      ok_q <= 1'b0;
      rd_q <= '0;
      case (op_q)
        bsst_pkg::OP_INSERT: if (cap_ok && !found) begin
          ok_q <= 1'b1;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CntW'(i) == pos_q) keys_q[i] <= key_q;
          end
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (CntW'(i) > pos_q && CntW'(i) <= count_q) keys_q[i] <= keys_q[i-1];
          end
        end
        bsst_pkg::OP_ERASE: if (found) begin
          ok_q <= 1'b1;
          for (int i = 0; i < MAX_ENTRIES - 1; i++)
            if (CntW'(i) >= pos_q) keys_q[i] <= keys_q[i+1];
        end
        bsst_pkg::OP_CONTAINS: ok_q <= found;
        bsst_pkg::OP_READ: if ((CntW + 4)'(rank_q) < (CntW + 4)'(count_q)) begin
          ok_q <= 1'b1;
          rd_q <= 32'(keys_q[IdxW'(rank_q)]);
        end
        default: ok_q <= 1'b0;
      endcase
    end
  end
endmodule

// ===== hdl/bounded_sorted_set_table_top.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_set_table_top: bounded sorted set of distinct keys
// Insert / erase / contains / rank read over an ascending key table.
// ----------------------------------------------------------------------------
// channel   dir  beat payload
// req       in   mode[1:0], key[31:0], rank[3:0]
// rsp       out  ok, read_key[31:0], entry_count[4:0]
// cfg       in   cfg_we_i / cfg_data_i (capacity_limit)
//
// Sequence: accept, then a linear lower-bound scan (one table entry
// compared per cycle), then the response beat.
// The next request is taken once the response beat is taken.
// Reset clears count and sets capacity to 16; the key table is not cleared.
// A stalled response holds until rsp.ready is seen.
module bounded_sorted_set_table_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  bsst_if.sink        req,
  bsst_if.source      rsp
);
  `include "assert_macros.svh"

  bsst_pkg::cmd_t cmd;
  bsst_pkg::sts_t sts;
  logic [31:0] rd_key;
  logic        ok;
  logic [4:0]  cnt;

  bsst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  // request payload packs {mode, key, rank}
  bsst_dp #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .mode_i(req.data[37:36]), .key_i(req.data[35:4]), .rank_i(req.data[3:0]),
    .ok_o(ok), .read_key_o(rd_key), .entry_count_o(cnt)
  );

  // response payload packs {ok, read_key, entry_count}
  assign rsp.data = {ok, rd_key, cnt};

  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt <= 5'(MAX_ENTRIES))
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, rsp.valid, !req.ready)
  `ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, cmd.commit, rsp.valid)
endmodule
